[hw/rtl/frc_pkg.sv]
// ----------------------------------------------------------------------------
// frc_pkg
// Shared types, result kind codes and the CRC byte update for the fragment
// reassembly checker.
// ----------------------------------------------------------------------------
package frc_pkg;

    // result kinds
    localparam logic [2:0] KIND_PAYLOAD  = 3'd0;
    localparam logic [2:0] KIND_GOOD     = 3'd1;
    localparam logic [2:0] KIND_CRC_BAD  = 3'd2;
    localparam logic [2:0] KIND_ABORT    = 3'd3;
    localparam logic [2:0] KIND_ORDER    = 3'd4;
    localparam logic [2:0] KIND_DUP      = 3'd5;
    localparam logic [2:0] KIND_SHORT    = 3'd6;
    localparam logic [2:0] KIND_LINK_ERR = 3'd7;

    // fragment modes
    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_START   = 2'd1;
    localparam logic [1:0] MODE_PAYLOAD = 2'd2;

    localparam logic [7:0]  LAST_FLAG = 8'h80;
    localparam logic [15:0] CRC_POLY  = 16'h1021;

    // result queue depth
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] link_port;
        logic       frag_begin;
        logic       frag_end;
        logic       link_ok;
    } t_in_word;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] payload;
        logic [7:0] frame_port;
        logic       run_end;
    } t_res;

    typedef struct packed {
        logic [1:0]     cnt;
        t_res [1:0]     res;
    } t_res_pair;

    // CCITT CRC, MSB first, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[hw/rtl/frc_core.sv]
// ----------------------------------------------------------------------------
// frc_core
// Input register, reassembly state and the per-word decision logic. Yields
// up to two results per word.
// ----------------------------------------------------------------------------
module frc_core import frc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in_word,
    input  logic        i_room,
    output t_res_pair   o_push
);

    logic        r_in_vld;
    t_in_word    r_in;
    logic        fire;

    logic [15:0] r_crc_seed;
    logic        r_in_frame,  n_in_frame;
    logic [7:0]  r_exp_num,   n_exp_num;
    logic [7:0]  r_owner,     n_owner;
    logic [15:0] r_crc_exp,   n_crc_exp;
    logic [15:0] r_run_crc,   n_run_crc;
    logic [1:0]  r_hdr_cnt,   n_hdr_cnt;
    logic [7:0]  r_hdr_byte,  n_hdr_byte;
    logic [15:0] r_pend_crc,  n_pend_crc;
    logic [1:0]  r_mode,      n_mode;

    logic [6:0]  num;
    logic [8:0]  exp_inc;
    logic        finish;
    t_res_pair   push;

    assign fire       = r_in_vld & i_room;
    assign o_in_ready = ~r_in_vld | fire;
    assign num        = r_in.data_byte[6:0];
    assign exp_inc    = {1'b0, r_exp_num} + 9'd1;

    always_comb begin
        n_in_frame = r_in_frame;
        n_exp_num  = r_exp_num;
        n_owner    = r_owner;
        n_crc_exp  = r_crc_exp;
        n_run_crc  = r_run_crc;
        n_hdr_cnt  = r_hdr_cnt;
        n_hdr_byte = r_hdr_byte;
        n_pend_crc = r_pend_crc;
        n_mode     = r_mode;
        finish     = 1'b0;
        push       = '0;

        if (fire) begin
            if (r_in.frag_begin) begin
                n_hdr_cnt = 2'd0;
                if (!r_in.link_ok) begin
                    push.res[0] = '{KIND_LINK_ERR, 8'd0, r_owner, 1'b0};
                    push.cnt    = 2'd1;
                    n_mode      = MODE_IDLE;
                end else begin
                    n_hdr_byte = r_in.data_byte;
                    if (num == 7'd0) begin
                        n_mode    = MODE_START;
                        n_hdr_cnt = 2'd1;
                        if (r_in.frag_end) begin
                            push.res[0] = '{KIND_SHORT, 8'd0, r_owner, 1'b0};
                            push.cnt    = 2'd1;
                            n_mode      = MODE_IDLE;
                        end
                    end else if (!r_in_frame) begin
                        push.res[0] = '{KIND_ORDER, 8'd0, r_owner, 1'b0};
                        push.cnt    = 2'd1;
                        n_mode      = MODE_IDLE;
                    end else if ({1'b0, num} == r_exp_num && r_in.link_port == r_owner) begin
                        push.res[0] = '{KIND_DUP, 8'd0, r_owner, 1'b0};
                        push.cnt    = 2'd1;
                        n_mode      = MODE_IDLE;
                    end else if ({2'b0, num} != exp_inc || r_in.link_port != r_owner) begin
                        push.res[0] = '{KIND_ABORT, 8'd0, r_owner, 1'b0};
                        push.res[1] = '{KIND_ORDER, 8'd0, r_owner, 1'b0};
                        push.cnt    = 2'd2;
                        n_in_frame  = 1'b0;
                        n_mode      = MODE_IDLE;
                    end else begin
                        n_exp_num = exp_inc[7:0];
                        n_mode    = MODE_PAYLOAD;
                        finish    = r_in.frag_end;
                    end
                end
            end else if (r_mode == MODE_START) begin
                if (r_hdr_cnt == 2'd1) begin
                    n_pend_crc = {8'd0, r_in.data_byte};
                    n_hdr_cnt  = 2'd2;
                    if (r_in.frag_end) begin
                        push.res[0] = '{KIND_SHORT, 8'd0, r_owner, 1'b0};
                        push.cnt    = 2'd1;
                        n_mode      = MODE_IDLE;
                    end
                end else begin
                    n_pend_crc = {r_in.data_byte, r_pend_crc[7:0]};
                    n_hdr_cnt  = 2'd3;
                    if (r_in_frame) begin
                        push.res[0] = '{KIND_ABORT, 8'd0, r_owner, 1'b0};
                        push.cnt    = 2'd1;
                    end
                    n_in_frame = 1'b1;
                    n_exp_num  = 8'd0;
                    n_owner    = r_in.link_port;
                    n_crc_exp  = n_pend_crc;
                    n_run_crc  = r_crc_seed;
                    n_mode     = MODE_PAYLOAD;
                    finish     = r_in.frag_end;
                end
            end else if (r_mode == MODE_PAYLOAD) begin
                push.res[0] = '{KIND_PAYLOAD, r_in.data_byte, r_owner, 1'b0};
                push.cnt    = 2'd1;
                n_run_crc   = crc_byte(r_run_crc, r_in.data_byte);
                finish      = r_in.frag_end;
            end
        end

        // close the fragment; give the verdict on the last one
        if (finish) begin
            if ((n_hdr_byte & LAST_FLAG) != 8'd0) begin
                push.res[push.cnt[0]] = '{(n_run_crc == n_crc_exp) ? KIND_GOOD : KIND_CRC_BAD,
                                          8'd0, n_owner, 1'b0};
                push.cnt   = push.cnt + 2'd1;
                n_in_frame = 1'b0;
            end
            n_mode = MODE_IDLE;
        end

        if (push.cnt == 2'd1) begin
            push.res[0].run_end = 1'b1;
        end else if (push.cnt == 2'd2) begin
            push.res[1].run_end = 1'b1;
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_crc_seed <= 16'd0;
            r_in_frame <= 1'b0;
            r_exp_num  <= 8'd0;
            r_owner    <= 8'd0;
            r_crc_exp  <= 16'd0;
            r_run_crc  <= 16'd0;
            r_hdr_cnt  <= 2'd0;
            r_hdr_byte <= 8'd0;
            r_pend_crc <= 16'd0;
            r_mode     <= MODE_IDLE;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (i_cfg_wr_en) begin
                r_crc_seed <= i_cfg_wr_data;
            end
            r_in_frame <= n_in_frame;
            r_exp_num  <= n_exp_num;
            r_owner    <= n_owner;
            r_crc_exp  <= n_crc_exp;
            r_run_crc  <= n_run_crc;
            r_hdr_cnt  <= n_hdr_cnt;
            r_hdr_byte <= n_hdr_byte;
            r_pend_crc <= n_pend_crc;
            r_mode     <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_word;
        end
    end

endmodule

[hw/rtl/frc_outq.sv]
// ----------------------------------------------------------------------------
// frc_outq
// Small result queue; takes zero, one or two results a cycle and hands out
// one result word per output handshake.
// ----------------------------------------------------------------------------
module frc_outq import frc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_res_pair i_push,
    output logic      o_room,
    output logic      o_valid,
    input  logic      i_ready,
    output t_res      o_res
);

    t_res           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_cnt;
    logic           pop;
    logic [QAW-1:0] wp1;

    // keep room for a two-result word
    assign o_room  = r_cnt <= (QAW+1)'(QDEPTH - 2);
    assign o_valid = r_cnt != '0;
    assign o_res   = r_mem[r_rp];
    assign pop     = o_valid & i_ready;
    assign wp1     = r_wp + QAW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + QAW'(i_push.cnt);
            r_rp  <= r_rp + QAW'(pop);
            r_cnt <= r_cnt + (QAW+1)'(i_push.cnt) - (QAW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wp] <= i_push.res[0];
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wp1] <= i_push.res[1];
        end
    end

endmodule

[hw/rtl/fragment_reassembly_checker.sv]
// ----------------------------------------------------------------------------
// fragment_reassembly_checker
// Checks received fragments byte by byte: order, port, duplicates, start
// header and the frame CRC. Payload bytes pass through; verdicts follow.
// ----------------------------------------------------------------------------
// Path: an accepted input word is held in the input register; its results then
//   go into the result queue, from which each result word is offered.
// Throughput: one input word per cycle while the queue holds two results or
//   fewer; a two-result word adds one net entry, so a run of them stalls input.
// Reset: synchronous, active low; clears the reassembly state, the CRC seed
//   and the result queue. The block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module fragment_reassembly_checker import frc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: CRC seed
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    // input words
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [7:0] data_byte, [15:8] link_port
    input  logic [1:0]  i_s_axis_tuser,   // [0] frag_begin, [1] link_ok
    input  logic        i_s_axis_tlast,   // frag_end
    // result words
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [7:0] payload, [15:8] frame_port
    output logic [2:0]  o_m_axis_tuser,   // [2:0] kind
    output logic        o_m_axis_tlast    // run_end
);

    t_in_word  in_word;
    t_res_pair push;
    logic      room;
    t_res      res;

    // unpack the input word
    assign in_word.data_byte  = i_s_axis_tdata[7:0];
    assign in_word.link_port  = i_s_axis_tdata[15:8];
    assign in_word.frag_begin = i_s_axis_tuser[0];
    assign in_word.link_ok    = i_s_axis_tuser[1];
    assign in_word.frag_end   = i_s_axis_tlast;

    // Decision stage: register the word, then evaluate it against the
    // reassembly state in one pass. It advances only when the queue can take
    // two results, so a stalled output backs up into o_s_axis_tready.
    frc_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_s_axis_tvalid),
        .o_in_ready    (o_s_axis_tready),
        .i_in_word     (in_word),
        .i_room        (room),
        .o_push        (push)
    );

    // Result queue: hold results until the sink takes them.
    frc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (res)
    );

    // pack the result word
    assign o_m_axis_tdata = {res.frame_port, res.payload};
    assign o_m_axis_tuser = res.kind;
    assign o_m_axis_tlast = res.run_end;

endmodule

[hw/rtl/frc_checker.sv]
// ----------------------------------------------------------------------------
// frc_checker
// Port-level checks on the fragment reassembly checker, bound to the top.
// ----------------------------------------------------------------------------
module frc_checker import frc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_s_axis_tready,
    input  logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [15:0] o_m_axis_tdata,
    input  logic [2:0]  o_m_axis_tuser,
    input  logic        o_m_axis_tlast
);

    // reset empties the queue and opens the input
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("outputs not clean after reset");

    // a held result word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata)
            && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast))
        else $error("result word changed while stalled");

    // non-payload results carry a zero payload byte
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != KIND_PAYLOAD |-> o_m_axis_tdata[7:0] == 8'd0)
        else $error("payload byte set on a status result");

    // only payload and abort can be followed by a second result of the word
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != KIND_PAYLOAD && o_m_axis_tuser != KIND_ABORT
            |-> o_m_axis_tlast)
        else $error("status result not marked as last of its word");

endmodule

bind fragment_reassembly_checker frc_checker u_frc_checker (.*);

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the fragment reassembly checker. Fragments are built
// as byte streams (start headers with frame CRC, numbered follow-on fragments,
// duplicates, gaps, port changes, link errors, short headers, missing ends and
// stray bytes) and pushed through the input stream with random gaps. A
// scoreboard tracks the reassembly state, predicts every result word and
// compares each one leaving the block, field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
    import frc_pkg::*;

    typedef logic [7:0] t_byte_q[$];

    localparam int ITEM_TARGET = 750;
    localparam int STALL_LIMIT = 2000;   // cycles without any word moving
    localparam int HOLD_CYCLES = 400;    // long receiver hold-off
    localparam int SETTLE      = 8;      // cycles after drain before a seed write

    // ------------------------------------------------------------------------
    // Scoreboard: its own copy of the reassembly state and the CRC seed, plus
    // the queue of result words still owed by the block.
    // ------------------------------------------------------------------------
    class t_frag_scoreboard;
        logic [15:0] seed;
        bit          open;
        logic [7:0]  last_num;
        logic [7:0]  own_port;
        logic [7:0]  hdr;
        logic [15:0] want_crc;
        logic [15:0] crc_acc;
        logic [15:0] crc_hold;
        logic [1:0]  hdr_cnt;
        logic [1:0]  mode;
        t_res        step_res[$];
        t_res        owed_q[$];

        function new();
            seed     = '0;
            open     = 1'b0;
            last_num = '0;
            own_port = '0;
            hdr      = '0;
            want_crc = '0;
            crc_acc  = '0;
            crc_hold = '0;
            hdr_cnt  = '0;
            mode     = MODE_IDLE;
        endfunction

        // CCITT update, one bit at a time, MSB first
        function logic [15:0] ccitt_next(input logic [15:0] c, input logic [7:0] d);
            logic fb;
            for (int i = 7; i >= 0; i--) begin
                fb = c[15] ^ d[i];
                c  = {c[14:0], 1'b0};
                if (fb) begin
                    c = c ^ 16'h1021;
                end
            end
            return c;
        endfunction

        function void add(input logic [2:0] k, input logic [7:0] p);
            if (step_res.size() < 2) begin
                step_res.push_back('{kind: k, payload: p, frame_port: own_port, run_end: 1'b0});
            end
        endfunction

        // end of an accepted fragment: a last fragment closes the frame with a verdict
        function void close_frag();
            if (hdr[7]) begin
                add((crc_acc == want_crc) ? KIND_GOOD : KIND_CRC_BAD, 8'h00);
                open = 1'b0;
            end
            mode = MODE_IDLE;
        endfunction

        // note one accepted input word; returns 1 if the block acts on it
        function bit note_word(input t_in_word w);
            bit         acted;
            logic [6:0] num;
            acted = w.frag_begin || mode == MODE_START || mode == MODE_PAYLOAD;
            num   = w.data_byte[6:0];
            step_res = {};
            if (w.frag_begin) begin
                hdr_cnt = 2'd0;
                if (!w.link_ok) begin
                    add(KIND_LINK_ERR, 8'h00);
                    mode = MODE_IDLE;
                end else begin
                    hdr = w.data_byte;
                    if (num == 7'd0) begin
                        mode    = MODE_START;
                        hdr_cnt = 2'd1;
                        if (w.frag_end) begin
                            add(KIND_SHORT, 8'h00);
                            mode = MODE_IDLE;
                        end
                    end else if (!open) begin
                        add(KIND_ORDER, 8'h00);
                        mode = MODE_IDLE;
                    end else if (8'(num) == last_num && w.link_port == own_port) begin
                        add(KIND_DUP, 8'h00);
                        mode = MODE_IDLE;
                    end else if (9'(num) != 9'(last_num) + 9'd1 || w.link_port != own_port) begin
                        add(KIND_ABORT, 8'h00);
                        add(KIND_ORDER, 8'h00);
                        open = 1'b0;
                        mode = MODE_IDLE;
                    end else begin
                        last_num = last_num + 8'd1;
                        mode     = MODE_PAYLOAD;
                        if (w.frag_end) begin
                            close_frag();
                        end
                    end
                end
            end else if (mode == MODE_START) begin
                if (hdr_cnt == 2'd1) begin
                    crc_hold = {8'h00, w.data_byte};
                    hdr_cnt  = 2'd2;
                    if (w.frag_end) begin
                        add(KIND_SHORT, 8'h00);
                        mode = MODE_IDLE;
                    end
                end else begin
                    // header complete: abort any open frame, then open the new one
                    crc_hold = {w.data_byte, crc_hold[7:0]};
                    hdr_cnt  = 2'd3;
                    if (open) begin
                        add(KIND_ABORT, 8'h00);
                    end
                    open     = 1'b1;
                    last_num = 8'd0;
                    own_port = w.link_port;
                    want_crc = crc_hold;
                    crc_acc  = seed;
                    mode     = MODE_PAYLOAD;
                    if (w.frag_end) begin
                        close_frag();
                    end
                end
            end else if (mode == MODE_PAYLOAD) begin
                add(KIND_PAYLOAD, w.data_byte);
                crc_acc = ccitt_next(crc_acc, w.data_byte);
                if (w.frag_end) begin
                    close_frag();
                end
            end
            if (step_res.size() > 0) begin
                step_res[step_res.size() - 1].run_end = 1'b1;
            end
            foreach (step_res[i]) begin
                owed_q.push_back(step_res[i]);
            end
            return acted;
        endfunction

        // compare one result word with the oldest owed one
        function bit check_word(input t_res got, output string msg);
            t_res want;
            msg = "";
            if (owed_q.size() == 0) begin
                msg = $sformatf("unexpected word: kind %0d payload %02h port %02h last %0b",
                                got.kind, got.payload, got.frame_port, got.run_end);
                return 1'b0;
            end
            want = owed_q.pop_front();
            if (got.kind !== want.kind || got.payload !== want.payload ||
                    got.frame_port !== want.frame_port || got.run_end !== want.run_end) begin
                msg = $sformatf("got/want kind %0d/%0d payload %02h/%02h port %02h/%02h last %0b/%0b",
                                got.kind, want.kind, got.payload, want.payload,
                                got.frame_port, want.frame_port, got.run_end, want.run_end);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_valid   = 1'b0;
    logic [15:0] s_data    = '0;
    logic [1:0]  s_user    = '0;
    logic        s_last    = 1'b0;
    logic        m_ready   = 1'b0;

    logic        s_ready;
    logic        m_valid;
    logic [15:0] m_data;
    logic [2:0]  m_user;
    logic        m_last;

    t_frag_scoreboard sb;
    int  err_cnt   = 0;
    int  item_cnt  = 0;      // words the block acts on
    int  quiet_cnt = 0;      // watchdog count
    bit  idle_on   = 1'b1;   // random gaps and stalls allowed
    bit  hold_req  = 1'b0;   // ask the receiver for one long hold-off
    t_res  got_word;
    string chk_msg;

    always #5 clk = ~clk;

    fragment_reassembly_checker u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),      // [7:0] data_byte, [15:8] link_port
        .i_s_axis_tuser  (s_user),      // [0] frag_begin, [1] link_ok
        .i_s_axis_tlast  (s_last),      // frag_end
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),      // [7:0] payload, [15:8] frame_port
        .o_m_axis_tuser  (m_user),      // [2:0] kind
        .o_m_axis_tlast  (m_last)       // run_end
    );

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        err_cnt++;
    endtask

    // ------------------------------------------------------------------------
    // Result side: stall in random bursts, hold off once for a long stretch
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            @(negedge clk);
            if (hold_req) begin
                // hold off long enough for the result queue and input to fill
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 9)) @(negedge clk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // check every accepted result word against the oldest owed one
    always @(posedge clk) begin
        if (rst_n && m_valid && m_ready) begin
            got_word = '{kind: m_user, payload: m_data[7:0], frame_port: m_data[15:8],
                         run_end: m_last};
            if (!sb.check_word(got_word, chk_msg)) begin
                report_mismatch(chk_msg);
            end
        end
    end

    // watchdog: end the run when nothing moves for too long
    always @(posedge clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cnt = 0;
        end else begin
            quiet_cnt++;
        end
        if (quiet_cnt >= STALL_LIMIT) begin
            $display("TIMEOUT @%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // offer one word and hold it until accepted; valid stays up on return
    task automatic send_word(input logic [7:0] d, input bit beg, input bit fin,
                             input logic [7:0] port, input bit ok);
        t_in_word w;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {port, d};
        s_user  <= {ok, beg};
        s_last  <= fin;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        w.data_byte  = d;
        w.link_port  = port;
        w.frag_begin = beg;
        w.frag_end   = fin;
        w.link_ok    = ok;
        if (sb.note_word(w)) begin
            item_cnt++;
        end
        @(negedge clk);
    endtask

    // drop valid and wait until every owed result word is out, then settle
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_seed(input logic [15:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.seed = v;
    endtask

    function automatic logic [15:0] crc_of(input logic [15:0] c, input t_byte_q q);
        foreach (q[i]) begin
            c = sb.ccitt_next(c, q[i]);
        end
        return c;
    endfunction

    // send one fragment: header (plus CRC for fragment 0) and body;
    // keep = bytes to send (0 for all), close = mark the last sent byte as end
    task automatic send_fragment(input logic [6:0] num, input bit last, input logic [15:0] crc,
                                 input t_byte_q body, input logic [7:0] port, input bit ok,
                                 input int keep, input bit close);
        t_byte_q bytes;
        bytes.push_back({last, num});
        if (num == 7'd0) begin
            bytes.push_back(crc[7:0]);
            bytes.push_back(crc[15:8]);
        end
        foreach (body[i]) begin
            bytes.push_back(body[i]);
        end
        if (keep <= 0 || keep > bytes.size()) begin
            keep = bytes.size();
        end
        for (int i = 0; i < keep; i++) begin
            send_word(bytes[i], i == 0, close && i == keep - 1, port, ok);
        end
    endtask

    // a well-formed frame with random content, now and then broken on purpose
    task automatic send_random_frame();
        t_byte_q     flat;
        t_byte_q     body;
        int          len[12];
        int          nf;
        int          off;
        int          fault;
        logic [15:0] crc;
        logic [7:0]  port;
        nf = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        for (int f = 0; f < nf; f++) begin
            len[f] = $urandom_range(0, 6);
            for (int j = 0; j < len[f]; j++) begin
                flat.push_back(8'($urandom_range(0, 255)));
            end
        end
        crc = crc_of(sb.seed, flat);
        if ($urandom_range(0, 4) == 0) begin
            crc = 16'($urandom_range(0, 16'hFFFF));
        end
        port = 8'($urandom_range(0, 255));
        off  = 0;
        for (int f = 0; f < nf; f++) begin
            body = {};
            for (int j = 0; j < len[f]; j++) begin
                body.push_back(flat[off + j]);
            end
            off  += len[f];
            fault = $urandom_range(0, 39);
            case (fault)
                0: begin
                    // bad reception first, then the clean copy
                    send_fragment(7'(f), f == nf - 1, crc, body, port, 1'b0, 0, 1'b1);
                    send_fragment(7'(f), f == nf - 1, crc, body, port, 1'b1, 0, 1'b1);
                end
                1: begin
                    // same fragment twice
                    send_fragment(7'(f), f == nf - 1, crc, body, port, 1'b1, 0, 1'b1);
                    send_fragment(7'(f), f == nf - 1, crc, body, port, 1'b1, 0, 1'b1);
                end
                2: begin
                    // skip a number and drop the rest of the frame
                    send_fragment(7'(f + 1), f == nf - 1, crc, body, port, 1'b1, 0, 1'b1);
                    return;
                end
                3: begin
                    send_fragment(7'(f), f == nf - 1, crc, body,
                                  port ^ 8'($urandom_range(1, 255)), 1'b1, 0, 1'b1);
                    return;
                end
                4: begin
                    // cut the fragment short with no end marker
                    send_fragment(7'(f), f == nf - 1, crc, body, port, 1'b1,
                                  $urandom_range(1, len[f] + ((f == 0) ? 3 : 1)), 1'b0);
                end
                5: begin
                    if (f == 0) begin
                        send_fragment(7'd0, nf == 1, crc, body, port, 1'b1,
                                      $urandom_range(1, 2), 1'b1);
                        return;
                    end
                    send_fragment(7'(f), f == nf - 1, crc, body, port, 1'b1, 0, 1'b1);
                end
                6: begin
                    // stray bytes between fragments
                    repeat ($urandom_range(1, 3)) begin
                        send_word(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)),
                                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    end
                    send_fragment(7'(f), f == nf - 1, crc, body, port, 1'b1, 0, 1'b1);
                end
                default: begin
                    send_fragment(7'(f), f == nf - 1, crc, body, port, 1'b1, 0, 1'b1);
                end
            endcase
        end
    endtask

    // run the numbering to its top, then offer one more fragment
    task automatic send_wrap_frame();
        t_byte_q none;
        for (int f = 0; f < 128; f++) begin
            send_fragment(7'(f), 1'b0, 16'h0000, none, 8'h5A, 1'b1, 0, 1'b1);
        end
        send_fragment(7'($urandom_range(1, 126)), 1'b1, 16'h0000, none, 8'h5A, 1'b1, 0, 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_byte_q     none;
        t_byte_q     b0;
        t_byte_q     b1;
        logic [15:0] crc;
        bit          wrap_done;
        bit          hold_done;
        int          next_cfg;
        int          cfg_round;
        sb        = new();
        wrap_done = 1'b0;
        hold_done = 1'b0;
        next_cfg  = 180;
        cfg_round = 0;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        write_seed(16'hFFFF);

        // directed: one of each case, field extremes included
        send_word(8'hFF, 1'b0, 1'b1, 8'hFF, 1'b1);     // stray byte, nothing open
        send_word(8'hFF, 1'b1, 1'b1, 8'h00, 1'b0);     // link error
        send_word(8'h85, 1'b1, 1'b1, 8'h12, 1'b1);     // fragment with no frame open
        send_fragment(7'd0, 1'b0, 16'h1234, none, 8'h00, 1'b1, 1, 1'b1);   // short header
        send_fragment(7'd0, 1'b1, 16'h1234, none, 8'h00, 1'b1, 2, 1'b1);   // short header
        b0 = '{8'h00, 8'hFF};
        b1 = '{8'hA5};
        crc = crc_of(crc_of(sb.seed, b0), b1);
        send_fragment(7'd0, 1'b0, crc, b0, 8'hFF, 1'b1, 0, 1'b1);          // good frame
        send_fragment(7'd1, 1'b1, crc, b1, 8'hFF, 1'b1, 0, 1'b1);
        send_fragment(7'd0, 1'b1, crc_of(sb.seed, b1) ^ 16'h8001, b1, 8'h80, 1'b1, 0, 1'b1);
        send_fragment(7'd0, 1'b0, 16'h0000, none, 8'h33, 1'b1, 0, 1'b1);
        send_fragment(7'd1, 1'b0, 16'h0000, b1, 8'h33, 1'b1, 0, 1'b1);
        send_fragment(7'd1, 1'b0, 16'h0000, b1, 8'h33, 1'b1, 0, 1'b1);     // duplicate
        send_fragment(7'd3, 1'b0, 16'h0000, b1, 8'h33, 1'b1, 0, 1'b1);     // gap
        send_fragment(7'd0, 1'b0, 16'h0000, none, 8'h44, 1'b1, 0, 1'b1);
        send_fragment(7'd1, 1'b0, 16'h0000, none, 8'h45, 1'b1, 0, 1'b1);   // port change
        send_fragment(7'd0, 1'b0, 16'h0000, none, 8'h01, 1'b1, 0, 1'b1);
        send_fragment(7'd0, 1'b0, 16'h0000, b0, 8'h02, 1'b1, 0, 1'b1);     // restart
        send_fragment(7'd1, 1'b1, 16'h0000, b0, 8'h02, 1'b1, 2, 1'b0);     // missing end
        send_fragment(7'd0, 1'b1, sb.seed, none, 8'h7F, 1'b1, 0, 1'b1);    // empty frame

        // sender pause: let everything drain, then move the seed to its other extreme
        wait_drained();
        write_seed(16'h0000);

        while (item_cnt < ITEM_TARGET) begin
            if (!wrap_done && item_cnt > 200) begin
                send_wrap_frame();
                wrap_done = 1'b1;
            end else begin
                send_random_frame();
            end
            if (!hold_done && item_cnt > 350) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (item_cnt >= next_cfg) begin
                wait_drained();
                case (cfg_round % 4)
                    0:       write_seed(16'h1D0F);
                    1:       write_seed(16'hFFFF);
                    2:       write_seed(16'h0000);
                    default: write_seed(16'($urandom_range(0, 16'hFFFF)));
                endcase
                cfg_round++;
                next_cfg += 180;
            end
            // no gaps or stalls in the closing stretch
            if (item_cnt > ITEM_TARGET - 100) begin
                idle_on = 1'b0;
            end
        end
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (sb.pending() != 0) begin
            report_mismatch($sformatf("%0d result words never arrived", sb.pending()));
        end
        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
